@@ rtl/lookahead_peak_limiter_core_assert.svh @@
// Assertion macros used by the limiter core RTL.
`ifndef LOOKAHEAD_PEAK_LIMITER_CORE_ASSERT_SVH
`define LOOKAHEAD_PEAK_LIMITER_CORE_ASSERT_SVH
`ifndef SYNTH
`define LPL_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define LPL_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define LPL_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define LPL_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

@@ rtl/lpl_pkg.sv @@
`default_nettype none
package lpl_pkg;
    localparam int GAIN_W  = 24;
    localparam int COEFF_W = 24;
    localparam int PRE_W   = 16;
    localparam int DLY_W   = 9;
    localparam logic [GAIN_W-1:0] GAIN_ONE = 24'd8388608;

    typedef enum logic [2:0] {
        REG_PRE_GAIN = 3'd0,
        REG_OUTPUT_GAIN = 3'd1,
        REG_ATTACK = 3'd2,
        REG_RELEASE = 3'd3,
        REG_DELAY = 3'd4
    } t_reg_idx;

    typedef enum logic [3:0] {
        ST_IDLE, ST_CLEAR, ST_DRIVE_L, ST_DRIVE_R, ST_WRITE, ST_TGT_DIV, ST_SMOOTH,
        ST_APPLY_L, ST_APPLY_R, ST_SAFE_DIV, ST_SAFE_WAIT, ST_SAFE_L, ST_SAFE_R, ST_TRIM_L,
        ST_TRIM_R, ST_OUT
    } t_state;

    typedef struct packed {
        logic start;
        logic busy;
    } t_div_ctl;
endpackage
`default_nettype wire

@@ rtl/lpl_recip.sv @@
`default_nettype none
// Restoring divider: quotient = floor((2^(NUM_W-1) + p/2) / p), one bit per cycle.
module lpl_recip
    import lpl_pkg::*;
#(
    parameter int NUM_W = 47,
    parameter int DEN_W = 29
) (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire               i_start,
    input  wire  [DEN_W-1:0]  i_den,
    output t_div_ctl          o_ctl,
    output logic [GAIN_W-1:0] o_quot
);
    localparam int CNT_W = $clog2(NUM_W + 1);
    localparam int QW = NUM_W + 1;

    logic [QW-1:0] r_num, n_num;
    logic [DEN_W:0] r_rem, n_rem;
    logic [DEN_W-1:0] r_den;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic r_busy;
    logic [DEN_W+1:0] w_trial;

    always_comb begin
        w_trial = {r_rem, r_num[QW-1]} - {2'b00, r_den};
        n_num = {r_num[QW-2:0], 1'b0};
        if (!w_trial[DEN_W+1]) begin
            n_rem = w_trial[DEN_W:0];
            n_num[0] = 1'b1;
        end else begin
            n_rem = {r_rem[DEN_W-1:0], r_num[QW-1]};
        end
        n_cnt = r_cnt - 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt <= CNT_W'(QW);
        end else if (r_busy) begin
            r_cnt <= n_cnt;
            if (n_cnt == '0) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_den <= i_den;
            r_rem <= '0;
            r_num <= (QW'(1) << (NUM_W - 1)) + QW'(i_den >> 1);
        end else if (r_busy) begin
            r_rem <= n_rem;
            r_num <= n_num;
        end
    end

    assign o_ctl.start = i_start;
    assign o_ctl.busy = r_busy;
    assign o_quot = r_num[GAIN_W-1:0];
endmodule
`default_nettype wire

@@ rtl/lookahead_peak_limiter_core.sv @@
// Each item passes through the drive, write, gain smoothing, apply, safety and trim states in
// order; a serial reciprocal division is added for each peak (driven or delayed) that exceeds one.
// The next item can be accepted in the cycle after the result is registered, and no new item is
// taken before then; a finished result waits in ST_OUT while the output port is still full.
// Reset (synchronous, active low) restores the configuration registers, gain one, write position
// zero, then clears every word of the delay memory before accepting items.
`default_nettype none
`include "lookahead_peak_limiter_core_assert.svh"
module lookahead_peak_limiter_core
    import lpl_pkg::*;
#(
    parameter int MAX_DELAY = 512,
    parameter int SAMPLE_WIDTH = 24
) (
    input  wire                           i_clk,
    input  wire                           i_rst_n,
    input  wire                           i_valid,
    output logic                          o_ready,
    input  wire  signed [SAMPLE_WIDTH-1:0] i_left_sample,
    input  wire  signed [SAMPLE_WIDTH-1:0] i_right_sample,
    output logic                          o_valid,
    input  wire                           i_ready,
    output logic signed [SAMPLE_WIDTH-1:0] o_left_out,
    output logic signed [SAMPLE_WIDTH-1:0] o_right_out,
    output logic [GAIN_W-1:0]             o_current_gain,
    input  wire                           i_cfg_valid,
    output logic                          o_cfg_ready,
    input  wire  [2:0]                    i_cfg_index,
    input  wire  [31:0]                   i_cfg_data
);
    localparam int FB = SAMPLE_WIDTH - 1;
    localparam int DW = SAMPLE_WIDTH + 4;      // stored driven sample
    localparam int AW = $clog2(MAX_DELAY);
    localparam int PW = 64;                    // wide product
    localparam logic signed [DW-1:0] S_ONE = DW'(1) <<< FB;

    // Configuration registers.
    logic [PRE_W-1:0] r_pre_gain;
    logic [GAIN_W-1:0] r_output_gain;
    logic [COEFF_W-1:0] r_attack, r_release;
    logic [DLY_W-1:0] r_delay;

    assign o_cfg_ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pre_gain <= 16'd4596;
            r_output_gain <= GAIN_ONE;
            r_attack <= 24'd16396000;
            r_release <= 24'd16775315;
            r_delay <= 9'd221;
        end else if (i_cfg_valid) begin
            case (t_reg_idx'(i_cfg_index))
                REG_PRE_GAIN: r_pre_gain <= i_cfg_data[PRE_W-1:0];
                REG_OUTPUT_GAIN: r_output_gain <= i_cfg_data[GAIN_W-1:0];
                REG_ATTACK: r_attack <= i_cfg_data[COEFF_W-1:0];
                REG_RELEASE: r_release <= i_cfg_data[COEFF_W-1:0];
                REG_DELAY: r_delay <= i_cfg_data[DLY_W-1:0];
                default: ;
            endcase
        end
    end

    // Effective line length: delay clamped to [1, MAX_DELAY-1], plus one.
    logic [AW:0] w_len;
    always_comb begin
        if (r_delay == '0) w_len = (AW+1)'(2);
        else if (32'(r_delay) > MAX_DELAY - 1) w_len = (AW+1)'(MAX_DELAY);
        else w_len = (AW+1)'(r_delay) + 1'b1;
    end

    // Delay memory: left and right packed into one word.
    logic [2*DW-1:0] mem [MAX_DELAY];
    logic [2*DW-1:0] r_rd;
    logic mem_we;
    logic [AW-1:0] mem_wa, mem_ra;
    logic [2*DW-1:0] mem_wd;
    always_ff @(posedge i_clk) begin
        if (mem_we) mem[mem_wa] <= mem_wd;
        r_rd <= mem[mem_ra];
    end

    t_state r_st, n_st;
    logic [AW:0] r_wp, r_clr;
    logic [GAIN_W-1:0] r_gain;
    logic signed [DW-1:0] r_dl, r_dr, r_ll, r_lr;
    logic signed [SAMPLE_WIDTH-1:0] r_in_l, r_in_r;
    logic signed [DW+GAIN_W:0] r_yl, r_yr;
    logic signed [SAMPLE_WIDTH-1:0] r_ol, r_or;
    logic [GAIN_W-1:0] r_tgt;
    logic r_div_go;
    logic r_out_v;

    // Shared multiplier: operands picked by state. Every operand fits a signed
    // word of DW+1 bits by GAIN_W+2 bits, so the product never exceeds PW bits.
    logic signed [DW:0] ma;
    logic signed [GAIN_W+1:0] mb;
    logic signed [PW-1:0] mp;
    assign mp = PW'(ma * mb);

    function automatic logic signed [PW-1:0] rnd(input logic signed [PW-1:0] v, input int s);
        rnd = (v + (PW'(1) <<< (s - 1))) >>> s;
    endfunction

    function automatic logic [DW-1:0] absd(input logic signed [DW-1:0] v);
        absd = v[DW-1] ? DW'(-v) : DW'(v);
    endfunction

    logic [DW-1:0] pk_a, pk_b, peak;
    logic div_start;
    t_div_ctl div_ctl;
    logic [GAIN_W-1:0] quot;
    logic [AW:0] rp;
    logic [AW:0] wpn;
    logic w_out_load;

    lpl_recip #(.NUM_W(FB + 24), .DEN_W(DW)) u_recip (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(div_start), .i_den(peak),
        .o_ctl(div_ctl), .o_quot(quot)
    );

    always_comb begin
        pk_a = (r_st == ST_SAFE_DIV) ? absd(r_ll) : absd(r_dl);
        pk_b = (r_st == ST_SAFE_DIV) ? absd(r_lr) : absd(r_dr);
        peak = (pk_b > pk_a) ? pk_b : pk_a;
        wpn = r_wp + 1'b1;
        rp = (wpn >= w_len) ? '0 : wpn;
        ma = '0;
        mb = '0;
        case (r_st)
            ST_DRIVE_L: begin ma = (DW+1)'(r_in_l); mb = (GAIN_W+2)'(r_pre_gain); end
            ST_DRIVE_R: begin ma = (DW+1)'(r_in_r); mb = (GAIN_W+2)'(r_pre_gain); end
            ST_SMOOTH: begin
                ma = (DW+1)'($signed({1'b0, r_gain}) - $signed({1'b0, r_tgt}));
                mb = (GAIN_W+2)'({2'b00, (r_tgt < r_gain) ? r_attack : r_release});
            end
            ST_APPLY_L: begin ma = (DW+1)'($signed(r_rd[DW-1:0])); mb = (GAIN_W+2)'(r_gain); end
            ST_APPLY_R: begin ma = (DW+1)'($signed(r_rd[2*DW-1:DW])); mb = (GAIN_W+2)'(r_gain); end
            ST_SAFE_L: begin ma = (DW+1)'(r_ll); mb = (GAIN_W+2)'(r_tgt); end
            ST_SAFE_R: begin ma = (DW+1)'(r_lr); mb = (GAIN_W+2)'(r_tgt); end
            ST_TRIM_L: begin ma = (DW+1)'(r_yl); mb = (GAIN_W+2)'(r_output_gain); end
            ST_TRIM_R: begin ma = (DW+1)'(r_yr); mb = (GAIN_W+2)'(r_output_gain); end
            default: ;
        endcase
    end

    // Next state. After the write the write position already points at the
    // oldest frame, so the memory is read there.
    always_comb begin
        n_st = r_st;
        div_start = 1'b0;
        mem_we = 1'b0;
        mem_wa = r_wp[AW-1:0];
        mem_ra = r_wp[AW-1:0];
        mem_wd = {r_dr, r_dl};
        case (r_st)
            ST_CLEAR: begin
                mem_we = 1'b1;
                mem_wa = r_clr[AW-1:0];
                mem_wd = '0;
                if (r_clr == (AW+1)'(MAX_DELAY - 1)) n_st = ST_IDLE;
            end
            ST_IDLE: if (i_valid) n_st = ST_DRIVE_L;
            ST_DRIVE_L: n_st = ST_DRIVE_R;
            ST_DRIVE_R: n_st = ST_WRITE;
            ST_WRITE: begin
                mem_we = 1'b1;
                if (peak > DW'(S_ONE)) begin
                    div_start = 1'b1;
                    n_st = ST_TGT_DIV;
                end else n_st = ST_SMOOTH;
            end
            ST_TGT_DIV: if (!div_ctl.busy && !r_div_go) n_st = ST_SMOOTH;
            ST_SMOOTH: n_st = ST_APPLY_L;
            ST_APPLY_L: n_st = ST_APPLY_R;
            ST_APPLY_R: n_st = ST_SAFE_DIV;
            ST_SAFE_DIV: begin
                if (peak > DW'(S_ONE)) begin
                    div_start = 1'b1;
                    n_st = ST_SAFE_WAIT;
                end else n_st = ST_SAFE_L;
            end
            ST_SAFE_WAIT: if (!div_ctl.busy && !r_div_go) n_st = ST_SAFE_L;
            ST_SAFE_L: n_st = ST_SAFE_R;
            ST_SAFE_R: n_st = ST_TRIM_L;
            ST_TRIM_L: n_st = ST_TRIM_R;
            ST_TRIM_R: n_st = ST_OUT;
            ST_OUT: if (w_out_load) n_st = ST_IDLE;
            default: n_st = ST_IDLE;
        endcase
    end

    assign o_ready = (r_st == ST_IDLE);

    // The finished frame moves to the output ports once they are free or are
    // being emptied in this cycle; until then it waits in ST_OUT.
    assign w_out_load = (r_st == ST_OUT) && (!r_out_v || i_ready);

    function automatic logic signed [SAMPLE_WIDTH-1:0] clampv(input logic signed [PW-1:0] v);
        if (v > PW'(S_ONE) - 1) clampv = SAMPLE_WIDTH'(S_ONE - 1);
        else if (v < -PW'(S_ONE)) clampv = SAMPLE_WIDTH'(-S_ONE);
        else clampv = SAMPLE_WIDTH'(v);
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= ST_CLEAR;
            r_clr <= '0;
            r_wp <= '0;
            r_gain <= GAIN_ONE;
            r_out_v <= 1'b0;
            r_div_go <= 1'b0;
        end else begin
            r_st <= n_st;
            if (r_st == ST_CLEAR) r_clr <= r_clr + 1'b1;
            if (w_out_load) r_out_v <= 1'b1;
            else if (o_valid && i_ready) r_out_v <= 1'b0;
            r_div_go <= div_start;
            case (r_st)
                ST_WRITE: begin
                    r_tgt <= GAIN_ONE;
                    r_wp <= rp;
                end
                ST_TGT_DIV: if (!div_ctl.busy && !r_div_go) r_tgt <= quot;
                ST_SMOOTH: r_gain <= GAIN_W'(r_tgt + GAIN_W'(rnd(mp, 24)));
                ST_APPLY_R: r_tgt <= GAIN_ONE;
                ST_SAFE_WAIT: if (!div_ctl.busy && !r_div_go) r_tgt <= quot;
                default: ;
            endcase
        end
    end

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_in_l <= i_left_sample;
            r_in_r <= i_right_sample;
        end
        if (w_out_load) begin
            o_left_out <= r_ol;
            o_right_out <= r_or;
            o_current_gain <= r_gain;
        end
        case (r_st)
            ST_DRIVE_L: r_dl <= DW'(rnd(mp, 12));
            ST_DRIVE_R: r_dr <= DW'(rnd(mp, 12));
            ST_APPLY_L: r_ll <= DW'(rnd(mp, 23));
            ST_APPLY_R: r_lr <= DW'(rnd(mp, 23));
            ST_SAFE_L: r_yl <= (DW+GAIN_W+1)'(rnd(mp, 23));
            ST_SAFE_R: r_yr <= (DW+GAIN_W+1)'(rnd(mp, 23));
            ST_TRIM_L: r_ol <= clampv(rnd(mp, 23));
            ST_TRIM_R: r_or <= clampv(rnd(mp, 23));
            default: ;
        endcase
    end

    assign o_valid = r_out_v;

    `LPL_ASSERT_IMPL(a_ready_idle, i_clk, i_rst_n, o_ready, r_st == ST_IDLE)
    `LPL_ASSERT_IMPL(a_gain_range, i_clk, i_rst_n, 1'b1, r_gain <= GAIN_ONE)
    `LPL_ASSERT_NEXT(a_out_follows, i_clk, i_rst_n, r_st == ST_OUT, o_valid)
endmodule
`default_nettype wire

@@ tb/tb.sv @@
`default_nettype none
module tb;
    import lpl_pkg::*;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_valid = 1'b0;
    logic               o_ready;
    logic signed [23:0] i_left_sample = '0;
    logic signed [23:0] i_right_sample = '0;
    logic               o_valid;
    logic               i_ready = 1'b0;
    logic signed [23:0] o_left_out;
    logic signed [23:0] o_right_out;
    logic [23:0]        o_current_gain;
    logic               i_cfg_valid = 1'b0;
    logic               o_cfg_ready;
    logic [2:0]         i_cfg_index = '0;
    logic [31:0]        i_cfg_data = '0;

    // A stereo frame as it should leave the limiter.
    typedef struct {
        logic signed [23:0] left;
        logic signed [23:0] right;
        logic [23:0]        gain;
    } t_limited_frame;

    // Tracks the limiter state and holds the frames still owed by the block.
    class limiter_scoreboard;
        longint         line_l[512];
        longint         line_r[512];
        int unsigned    wr_pos;
        longint         gain;
        longint         pre, trim, att, rel;
        int unsigned    dly;
        t_limited_frame owed[$];
        int             errors;

        function new();
            foreach (line_l[k]) begin
                line_l[k] = 0;
                line_r[k] = 0;
            end
            wr_pos = 0;
            gain = 64'd8388608;
            pre = 4596;
            trim = 8388608;
            att = 16396000;
            rel = 16775315;
            dly = 221;
            errors = 0;
        endfunction

        function longint rnd(longint v, int s);
            return (v + (longint'(1) <<< (s - 1))) >>> s;
        endfunction

        // Gain in Q1.23 that brings a peak above one back to one.
        function longint recip(longint pk);
            if (pk <= 64'd8388608) begin
                return 64'd8388608;
            end
            return ((longint'(1) <<< 46) + pk / 2) / pk;
        endfunction

        function longint clip(longint v);
            if (v > 8388607) begin
                return 8388607;
            end
            if (v < -8388608) begin
                return -8388608;
            end
            return v;
        endfunction

        function longint absv(longint v);
            return (v < 0) ? -v : v;
        endfunction

        function void set_reg(t_reg_idx idx, logic [31:0] data);
            case (idx)
                REG_PRE_GAIN:    pre = longint'(data[15:0]);
                REG_OUTPUT_GAIN: trim = longint'(data[23:0]);
                REG_ATTACK:      att = longint'(data[23:0]);
                REG_RELEASE:     rel = longint'(data[23:0]);
                REG_DELAY:       dly = 32'(data[8:0]);
                default: ;
            endcase
        endfunction

        function void note(logic signed [23:0] l, logic signed [23:0] r);
            longint         dl, dr, pk, tgt, cf, ll, lr, sf, yl, yr;
            int unsigned    d, len, rp;
            t_limited_frame f;
            d = dly;
            if (d < 1) d = 1;
            if (d > 511) d = 511;
            len = d + 1;
            dl = rnd(longint'(l) * pre, 12);
            dr = rnd(longint'(r) * pre, 12);
            line_l[wr_pos] = dl;
            line_r[wr_pos] = dr;
            pk = (absv(dr) > absv(dl)) ? absv(dr) : absv(dl);
            tgt = recip(pk);
            cf = (tgt < gain) ? att : rel;
            gain = tgt + rnd(cf * (gain - tgt), 24);
            rp = wr_pos + 1;
            if (rp >= len) rp = 0;
            ll = rnd(line_l[rp] * gain, 23);
            lr = rnd(line_r[rp] * gain, 23);
            pk = (absv(lr) > absv(ll)) ? absv(lr) : absv(ll);
            sf = recip(pk);
            yl = clip(rnd(rnd(ll * sf, 23) * trim, 23));
            yr = clip(rnd(rnd(lr * sf, 23) * trim, 23));
            wr_pos = (wr_pos + 1 >= len) ? 0 : wr_pos + 1;
            f.left = yl[23:0];
            f.right = yr[23:0];
            f.gain = gain[23:0];
            owed.push_back(f);
        endfunction

        task report(string what, longint got, longint want);
            errors++;
            $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
        endtask

        task check(logic signed [23:0] l, logic signed [23:0] r, logic [23:0] g);
            t_limited_frame f;
            if (owed.size() == 0) begin
                report("unexpected frame", l, 0);
                return;
            end
            f = owed.pop_front();
            if (l !== f.left) report("left", l, f.left);
            if (r !== f.right) report("right", r, f.right);
            if (g !== f.gain) report("gain", g, f.gain);
        endtask
    endclass

    limiter_scoreboard sb = new();
    int  long_hold = 0;   // cycles the sink must still refuse, set by the stimulus
    bit  no_idle = 1'b0;  // when set, neither side inserts gaps

    lookahead_peak_limiter_core DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .o_ready(o_ready),
        .i_left_sample(i_left_sample), .i_right_sample(i_right_sample),
        .o_valid(o_valid), .i_ready(i_ready),
        .o_left_out(o_left_out), .o_right_out(o_right_out),
        .o_current_gain(o_current_gain),
        .i_cfg_valid(i_cfg_valid), .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    // Short gaps are common, long ones rare.
    function int pick_gap();
        int r;
        if (no_idle) return 0;
        r = $urandom_range(99);
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(3, 1);
        return $urandom_range(40, 10);
    endfunction

    // Output sink. Outputs are sampled at the edge, before the block updates them.
    int stall_left = 0;
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) begin
            sb.check(o_left_out, o_right_out, o_current_gain);
        end
        if (long_hold > 0) begin
            long_hold--;
            i_ready <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left--;
            i_ready <= 1'b0;
        end else begin
            i_ready <= 1'b1;
            stall_left = pick_gap();
        end
    end

    // Register writes keep the valid high across back-to-back writes; the caller
    // lowers it once the whole group has gone through.
    task write_reg(t_reg_idx idx, logic [31:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        // Upper bits beyond the widest register (bit 24 and up) are junk and must be ignored.
        i_cfg_data <= val | ({$urandom} & ~((32'd1 << 24) - 1));
        do @(posedge i_clk); while (!o_cfg_ready);
        sb.set_reg(idx, val | ({$urandom} & ~((32'd1 << 24) - 1)));
    endtask

    // Offers one frame and returns at the edge where it was taken.
    task send_frame(logic signed [23:0] l, logic signed [23:0] r);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_left_sample <= l;
        i_right_sample <= r;
        do @(posedge i_clk); while (!o_ready);
        sb.note(l, r);
    endtask

    // Stops offering, waits until every owed frame is out, then lets the block settle.
    task drain();
        i_valid <= 1'b0;
        while (sb.owed.size() != 0) @(posedge i_clk);
        repeat (130) @(posedge i_clk);
    endtask

    // Audio-like random content: bursts of a chosen loudness, with occasional
    // full-range noise so that every input bit toggles.
    int burst_amp = 1000;
    int burst_left = 0;
    function logic signed [23:0] pick_sample();
        if (burst_left == 0) begin
            burst_left = $urandom_range(40, 5);
            case ($urandom_range(3))
                0: burst_amp = $urandom_range(4000);
                1: burst_amp = $urandom_range(8388607, 1000000);
                2: burst_amp = 8388607;
                default: burst_amp = $urandom_range(3000000, 100000);
            endcase
        end
        burst_left--;
        if ($urandom_range(19) == 0) return 24'($urandom);
        return 24'($signed($urandom_range(2 * burst_amp)) - burst_amp);
    endfunction

    task random_config();
        write_reg(REG_PRE_GAIN, ($urandom_range(3) == 0) ? $urandom_range(65535)
                                                         : $urandom_range(64924, 4096));
        write_reg(REG_OUTPUT_GAIN, $urandom_range(8388608, 528634));
        write_reg(REG_ATTACK, $urandom_range(16777215));
        write_reg(REG_RELEASE, $urandom_range(16777215, 15000000));
        // Short lines most of the time so the delayed frames show up early.
        write_reg(REG_DELAY, ($urandom_range(4) == 0) ? $urandom_range(511) : $urandom_range(12));
        i_cfg_valid <= 1'b0;
    endtask

    initial begin
        logic signed [23:0] edge_vals[6];
        edge_vals = '{24'sh800000, 24'sh7FFFFF, 24'sh000000, 24'sh000001,
                      24'shFFFFFF, 24'sh400000};
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed frames at the reset settings: each extreme with itself and with one other.
        no_idle = 1'b1;
        @(posedge i_clk);
        foreach (edge_vals[a]) begin
            send_frame(edge_vals[a], edge_vals[5 - a]);
            send_frame(edge_vals[a], edge_vals[a]);
        end
        drain();

        // Extreme settings: zero delay (acts as one), release just below unity, output gain
        // above one, attack of zero, maximum drive.
        write_reg(REG_DELAY, 0);
        write_reg(REG_PRE_GAIN, 65535);
        write_reg(REG_OUTPUT_GAIN, 24'hFFFFFF);
        write_reg(REG_ATTACK, 0);
        write_reg(REG_RELEASE, 24'hFFFFFF);
        i_cfg_valid <= 1'b0;
        foreach (edge_vals[a]) send_frame(edge_vals[a], -edge_vals[a]);
        send_frame(24'sh100000, 24'sh000000);
        send_frame(24'sh000000, 24'shF00000);
        drain();

        // Longest line with a write position left over from the short one.
        write_reg(REG_DELAY, 511);
        write_reg(REG_PRE_GAIN, 4096);
        write_reg(REG_ATTACK, 24'hFFFFFF);
        write_reg(REG_RELEASE, 0);
        write_reg(REG_OUTPUT_GAIN, 528634);
        i_cfg_valid <= 1'b0;
        no_idle = 1'b0;
        repeat (600) send_frame(pick_sample(), pick_sample());
        drain();

        // Shrinking the line leaves the write position past its end.
        write_reg(REG_DELAY, 3);
        i_cfg_valid <= 1'b0;

        for (int phase = 0; phase < 6; phase++) begin
            if (phase > 0) begin
                drain();
                random_config();
            end
            if (phase == 1) begin
                // Sink holds off while frames keep coming, so the block backs up.
                long_hold = 400;
                no_idle = 1'b1;
                repeat (60) send_frame(pick_sample(), pick_sample());
                no_idle = 1'b0;
            end
            if (phase == 3) no_idle = 1'b1;
            repeat (110) send_frame(pick_sample(), pick_sample());
            no_idle = 1'b0;
        end
        i_valid <= 1'b0;
        drain();

        if (sb.errors == 0 && sb.owed.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

    initial begin
        #20000000;
        $display("== FAIL ==");
        $finish;
    end
endmodule
`default_nettype wire
